// ===== design/bruq_pkg.sv =====
// Shared types and codes for the buffered UART ring queues block.
// Used by bruq_ctrl, bruq_datapath and buffered_uart_ring_queues_top; no dependencies.
`default_nettype none

package bruq_pkg;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_READ  = 2'd1,
    OP_TXRDY = 2'd2,
    OP_RECV  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_DATA  = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_TX_FULL  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_TX_IDLE  = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic [7:0] line_byte;
    logic       line_valid;
    logic [7:0] forward_byte;
    logic       forward_valid;
    logic       transmit_request;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_POP  = 2'd2
  } state_t;

  typedef struct packed {
    logic load_cmd;
    logic exec;
    logic finish_pop;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic pop_needed;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/buffered_uart_ring_queues_top.sv =====
// Top level of the buffered UART ring queues: transmit and receive byte rings
// between a host and a UART line. Instantiates bruq_ctrl and bruq_datapath; uses bruq_pkg.
//
// Every input word gives exactly one output word. A word is taken into a command register
// and executed in the next cycle once the output register is free; words that do not pop
// a ring (send, refused or empty read, idle ready event, received byte) then follow one
// per clock while the output register is free. A successful host read or a ready event
// that pops a byte adds the pop state for the registered read port of the ring memory.
// The output register lets a new word be taken while a result waits. SEND_DEPTH and
// RECV_DEPTH set the ring sizes (4 to 256); a ring holds depth-1 bytes. The user must
// write forward_mode through cfg_we/cfg_wdata only while idle; it is not enforced.
`default_nettype none

module buffered_uart_ring_queues_top #(
  parameter int SEND_DEPTH = 16,
  parameter int RECV_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bruq_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bruq_pkg::out_word_t      out_word,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);

  bruq_pkg::ctrl_t ctl;
  bruq_pkg::stat_t stat;

  bruq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  bruq_datapath #(
    .SEND_DEPTH (SEND_DEPTH),
    .RECV_DEPTH (RECV_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ===== design/bruq_ctrl.sv =====
// Sequencer for the buffered UART ring queues: accept, execute, finish a ring pop.
// Depends on bruq_pkg for state, command and status types.
`default_nettype none

module bruq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bruq_pkg::stat_t stat,
  output bruq_pkg::ctrl_t      ctl
);

  bruq_pkg::state_t state;
  bruq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bruq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bruq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = bruq_pkg::S_EXEC;
        end
      end
      bruq_pkg::S_EXEC: begin
        if (stat.out_free) begin
          if (stat.pop_needed) begin
            state_next = bruq_pkg::S_POP;
          end else if (!in_valid) begin
            state_next = bruq_pkg::S_IDLE;
          end
        end
      end
      bruq_pkg::S_POP: begin
        state_next = bruq_pkg::S_IDLE;
      end
      default: begin
        state_next = bruq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    ctl.exec       = 1'b0;
    ctl.finish_pop = 1'b0;
    unique case (state)
      bruq_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      bruq_pkg::S_EXEC: begin
        ctl.exec = stat.out_free;
        in_ready = stat.out_free && !stat.pop_needed;
      end
      bruq_pkg::S_POP: begin
        ctl.finish_pop = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    ctl.load_cmd = in_valid && in_ready;
  end

  assert property (@(posedge clk) disable iff (rst) ctl.exec |-> stat.out_free)
    else $error("execute issued while the output register is busy");

  assert property (@(posedge clk) disable iff (rst)
    state == bruq_pkg::S_POP |-> $past(ctl.exec && stat.pop_needed))
    else $error("pop finish without a preceding pop");

  assert property (@(posedge clk) disable iff (rst)
    state == bruq_pkg::S_POP |=> state == bruq_pkg::S_IDLE)
    else $error("pop finish did not return to idle");

  assert property (@(posedge clk) disable iff (rst)
    ctl.load_cmd |=> state == bruq_pkg::S_EXEC)
    else $error("accepted word not held for execution");

endmodule

`default_nettype wire

// ===== design/bruq_datapath.sv =====
// Datapath for the buffered UART ring queues: command register, both rings,
// pointers, request flag, forward mode register and output register. Depends on bruq_pkg.
`default_nettype none

module bruq_datapath #(
  parameter int SEND_DEPTH = 16,
  parameter int RECV_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata,
  input  wire bruq_pkg::in_word_t   in_word,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output bruq_pkg::out_word_t       out_word,
  input  wire bruq_pkg::ctrl_t      ctl,
  output bruq_pkg::stat_t           stat
);

  localparam int SAW = $clog2(SEND_DEPTH);
  localparam int RAW = $clog2(RECV_DEPTH);
  localparam logic [SAW-1:0] SEND_LAST = SAW'(SEND_DEPTH - 1);
  localparam logic [RAW-1:0] RECV_LAST = RAW'(RECV_DEPTH - 1);

  bruq_pkg::in_word_t  cmd;
  logic                forward_mode;
  logic                request_flag;
  logic                request_flag_next;
  logic [SAW-1:0]      send_head;
  logic [SAW-1:0]      send_tail;
  logic [RAW-1:0]      recv_head;
  logic [RAW-1:0]      recv_tail;
  logic [SAW-1:0]      send_head_inc;
  logic [SAW-1:0]      send_tail_inc;
  logic [RAW-1:0]      recv_head_inc;
  logic [RAW-1:0]      recv_tail_inc;
  logic                send_empty;
  logic                send_full;
  logic                recv_empty;
  logic                recv_full;
  logic                send_push;
  logic                send_pop;
  logic                recv_push;
  logic                recv_pop;
  logic [7:0]          send_rdata;
  logic [7:0]          recv_rdata;
  logic [7:0]          send_mem [SEND_DEPTH];
  logic [7:0]          recv_mem [RECV_DEPTH];
  logic                out_load;
  bruq_pkg::out_word_t res;

  assign send_head_inc = (send_head == SEND_LAST) ? '0 : send_head + 1'b1;
  assign send_tail_inc = (send_tail == SEND_LAST) ? '0 : send_tail + 1'b1;
  assign recv_head_inc = (recv_head == RECV_LAST) ? '0 : recv_head + 1'b1;
  assign recv_tail_inc = (recv_tail == RECV_LAST) ? '0 : recv_tail + 1'b1;

  assign send_empty = (send_head == send_tail);
  assign send_full  = (send_head_inc == send_tail);
  assign recv_empty = (recv_head == recv_tail);
  assign recv_full  = (recv_head_inc == recv_tail);

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.pop_needed = (cmd.opcode == bruq_pkg::OP_READ && !forward_mode && !recv_empty) ||
                           (cmd.opcode == bruq_pkg::OP_TXRDY && !send_empty);

  always_comb begin
    res               = '0;
    request_flag_next = request_flag;
    send_push         = 1'b0;
    send_pop          = 1'b0;
    recv_push         = 1'b0;
    recv_pop          = 1'b0;
    res.status        = bruq_pkg::ST_OK;
    case (cmd.opcode)
      bruq_pkg::OP_SEND: begin
        if (send_full) begin
          res.status = bruq_pkg::ST_TX_FULL;
        end else begin
          send_push         = 1'b1;
          request_flag_next = 1'b1;
        end
      end
      bruq_pkg::OP_READ: begin
        if (forward_mode) begin
          res.status = bruq_pkg::ST_REFUSED;
        end else if (recv_empty) begin
          res.status = bruq_pkg::ST_NO_DATA;
        end else begin
          recv_pop = 1'b1;
        end
      end
      bruq_pkg::OP_TXRDY: begin
        if (send_empty) begin
          request_flag_next = 1'b0;
          res.status        = bruq_pkg::ST_TX_IDLE;
        end else begin
          send_pop = 1'b1;
        end
      end
      default: begin
        if (forward_mode) begin
          res.forward_byte  = cmd.data_byte;
          res.forward_valid = 1'b1;
        end else if (recv_full) begin
          res.status = bruq_pkg::ST_OVERFLOW;
        end else begin
          recv_push = 1'b1;
        end
      end
    endcase
    if (ctl.finish_pop) begin
      res.status        = bruq_pkg::ST_OK;
      request_flag_next = request_flag;
      if (cmd.opcode == bruq_pkg::OP_READ) begin
        res.read_byte = recv_rdata;
      end else begin
        res.line_byte  = send_rdata;
        res.line_valid = 1'b1;
      end
    end
    res.transmit_request = request_flag_next;
  end

  assign out_load = (ctl.exec && !stat.pop_needed) || ctl.finish_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_mode <= 1'b0;
      request_flag <= 1'b0;
      send_head    <= '0;
      send_tail    <= '0;
      recv_head    <= '0;
      recv_tail    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        forward_mode <= cfg_wdata;
      end
      if (ctl.exec) begin
        request_flag <= request_flag_next;
        if (send_push) begin
          send_head <= send_head_inc;
        end
        if (send_pop) begin
          send_tail <= send_tail_inc;
        end
        if (recv_push) begin
          recv_head <= recv_head_inc;
        end
        if (recv_pop) begin
          recv_tail <= recv_tail_inc;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_cmd) begin
      cmd <= in_word;
    end
    if (out_load) begin
      out_word <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && send_push) begin
      send_mem[send_head_inc] <= cmd.data_byte;
    end
    if (ctl.exec && send_pop) begin
      send_rdata <= send_mem[send_tail_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && recv_push) begin
      recv_mem[recv_head_inc] <= cmd.data_byte;
    end
    if (ctl.exec && recv_pop) begin
      recv_rdata <= recv_mem[recv_tail_inc];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (send_head <= SEND_LAST) && (send_tail <= SEND_LAST) &&
    (recv_head <= RECV_LAST) && (recv_tail <= RECV_LAST))
    else $error("ring pointer beyond ring depth");

  assert property (@(posedge clk) disable iff (rst) ctl.finish_pop |-> !out_valid)
    else $error("pop result would overwrite a waiting word");

endmodule

`default_nettype wire
